/* sv/stl_pkg.sv */
// Shared types, constants and helpers for the strip-to-triangle-list block.
// No dependencies; every other file in the project depends on this package.
`default_nettype none

package stl_pkg;

   localparam int INDEX_W = 16;
   localparam logic [INDEX_W-1:0] RESTART_INDEX = {INDEX_W{1'b1}};

   // Strip loading phase
   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_RUN    = 2'd2
   } phase_type;

   // One input item as held in the input register
   typedef struct packed {
      logic [INDEX_W-1:0] raw_index;
      logic               mesh_start;
   } in_item_type;

   // One assembled triangle
   typedef struct packed {
      logic [INDEX_W-1:0] tri_first;
      logic [INDEX_W-1:0] tri_second;
      logic [INDEX_W-1:0] tri_third;
   } triangle_type;

   // Handshake from the input stage toward the assembler
   typedef struct packed {
      logic        valid;
      in_item_type item;
   } stage_type;

   // Big-endian to host byte order
   function automatic logic [INDEX_W-1:0] swap_bytes(input logic [INDEX_W-1:0] raw);
      swap_bytes = {raw[7:0], raw[15:8]};
   endfunction

endpackage

`default_nettype wire

/* sv/stl_ifs.sv */
// Valid/ready channel interfaces for strip indices and output triangles.
// Depends on stl_pkg for the index width.
`default_nettype none

interface stl_req_if;
   logic                        valid;
   logic                        ready;
   logic [stl_pkg::INDEX_W-1:0] raw_index;
   logic                        mesh_start;

   modport source (output valid, output raw_index, output mesh_start, input ready);
   modport sink   (input valid, input raw_index, input mesh_start, output ready);
endinterface

interface stl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [stl_pkg::INDEX_W-1:0] tri_first;
   logic [stl_pkg::INDEX_W-1:0] tri_second;
   logic [stl_pkg::INDEX_W-1:0] tri_third;

   modport source (output valid, output tri_first, output tri_second, output tri_third,
                   input ready);
   modport sink   (input valid, input tri_first, input tri_second, input tri_third,
                   output ready);
endinterface

`default_nettype wire

/* sv/stl_input_reg.sv */
// Input register: captures one strip index item per cycle from the request channel when free.
// Depends on stl_pkg and stl_req_if.
`default_nettype none

module stl_input_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   stl_req_if.sink               req_chan,
   input  wire logic             advance,
   output stl_pkg::stage_type    stage
);
   import stl_pkg::*;

   logic        valid_ff, valid_in;
   in_item_type item_ff, item_in;
   logic        take;

   // Free when empty or when the held item moves on this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in           = 1'b1;
         item_in.raw_index  = req_chan.raw_index;
         item_in.mesh_start = req_chan.mesh_start;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

/* sv/stl_assembler.sv */
// Strip state and triangle assembly: vertex window, load phase, winding flag.
// Depends on stl_pkg.
`default_nettype none

module stl_assembler (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire stl_pkg::in_item_type item,
   output logic                  emit,
   output stl_pkg::triangle_type triangle
);
   import stl_pkg::*;

   logic [INDEX_W-1:0] older_ff, older_in;
   logic [INDEX_W-1:0] newer_ff, newer_in;
   phase_type          phase_ff, phase_in;
   logic               flip_ff, flip_in;

   logic [INDEX_W-1:0] c_idx;
   phase_type          phase_eff;
   logic               flip_eff;
   logic               degenerate;

   assign c_idx      = swap_bytes(item.raw_index);
   assign degenerate = (older_ff == newer_ff) || (newer_ff == c_idx) ||
                       (c_idx == older_ff);

   // Next strip state and triangle for the item in the input register
   always_comb begin
      phase_eff = item.mesh_start ? PHASE_FIRST : phase_ff;
      flip_eff  = item.mesh_start ? 1'b0 : flip_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      phase_in  = phase_eff;
      flip_in   = flip_eff;
      emit      = 1'b0;
      triangle  = '{tri_first: older_ff, tri_second: newer_ff, tri_third: c_idx};
      case (phase_eff)
         PHASE_FIRST: begin
            older_in = c_idx;
            phase_in = PHASE_SECOND;
         end
         PHASE_SECOND: begin
            newer_in = c_idx;
            phase_in = PHASE_RUN;
         end
         default: begin
            if (c_idx == RESTART_INDEX) begin
               phase_in = PHASE_FIRST;
               flip_in  = 1'b0;
            end else begin
               flip_in  = !flip_eff;
               older_in = newer_ff;
               newer_in = c_idx;
               emit     = !degenerate;
               // The first triangle and every second one after it are reversed to keep a consistent winding
               if (!flip_eff) begin
                  triangle = '{tri_first: c_idx, tri_second: newer_ff,
                               tri_third: older_ff};
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         phase_ff <= PHASE_FIRST;
         flip_ff  <= 1'b0;
      end else if (advance) begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         phase_ff <= phase_in;
         flip_ff  <= flip_in;
      end
   end

endmodule

`default_nettype wire

/* sv/stl_output_reg.sv */
// Result register: holds one triangle for the response channel.
// Depends on stl_pkg and stl_rsp_if.
`default_nettype none

module stl_output_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic             load_valid,
   input  wire stl_pkg::triangle_type triangle,
   output logic                  can_take,
   stl_rsp_if.source             rsp_chan
);
   import stl_pkg::*;

   logic         valid_ff, valid_in;
   triangle_type data_ff, data_in;

   // Room when empty or when the held triangle leaves this cycle
   assign can_take = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = load_valid;
         data_in  = triangle;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.tri_first  = data_ff.tri_first;
   assign rsp_chan.tri_second = data_ff.tri_second;
   assign rsp_chan.tri_third  = data_ff.tri_third;

endmodule

`default_nettype wire

/* sv/strip_to_triangle_list.sv */
// Top level: triangle-strip indices in, triangle-list triangles out.
// Depends on stl_pkg, stl_ifs, stl_input_reg, stl_assembler, stl_output_reg.
//
//   Port      Dir  Payload                               Per item
//   req_chan  in   raw_index[15:0], mesh_start           one strip index
//   rsp_chan  out  tri_first, tri_second, tri_third      one triangle
//
// One index per clock unless rsp_chan stalls; triangles leave from the result register.
// Throughput is set by the input register and the result register, each one deep.
// Reset (synchronous) empties both registers and clears the vertex window,
// load phase and winding flag. A stalled result holds the result register; the
// input register still drains into it once it empties, and req_chan.ready falls
// only when both are full.
`default_nettype none

module strip_to_triangle_list (
   input  wire logic clock,
   input  wire logic reset,
   stl_req_if.sink   req_chan,
   stl_rsp_if.source rsp_chan
);
   import stl_pkg::*;

   stage_type    stage;
   logic         can_take;
   logic         advance;
   logic         emit;
   triangle_type triangle;

   assign advance = stage.valid && can_take;

   stl_input_reg u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   stl_assembler u_asm (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (stage.item),
      .emit     (emit),
      .triangle (triangle)
   );

   stl_output_reg u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (emit),
      .triangle   (triangle),
      .can_take   (can_take),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
